[src/nnr_pkg.sv]
// Shared types and constants for the nearest-neighbor resizer.
// No dependencies; every other file of the block imports this package.
package nnr_pkg;

    localparam int CFG_W           = 9;
    localparam int CFG_IDX_W       = 2;
    localparam int COLOR_W         = 8;
    localparam int RGB_W           = 3 * COLOR_W;
    localparam int POS_W           = 2 * CFG_W;
    localparam int MAX_DIM_DEF     = 256;
    localparam int STORE_DEPTH_DEF = 65536;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH   = 2'd0,
        REG_IN_HEIGHT  = 2'd1,
        REG_OUT_WIDTH  = 2'd2,
        REG_OUT_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_FETCH = 1'b1
    } kind_t;

    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] ow;
        logic [CFG_W-1:0] oh;
        logic [CFG_W-1:0] rmx;
        logic [CFG_W-1:0] rmy;
        logic [POS_W-1:0] frame;
    } geom_t;

endpackage

[src/nnr_setup.sv]
// Configuration registers and the geometry sequencer (divide, multiply, reduce).
// Depends on nnr_pkg.
module nnr_setup import nnr_pkg::*; #(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    localparam int ADDR_W     = $clog2(STORE_DEPTH)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 restart,
    output geom_t                geom,
    output logic [ADDR_W-1:0]    qx_mod,
    output logic [ADDR_W-1:0]    qyiw_mod,
    output logic [ADDR_W-1:0]    iw_mod
);

    localparam int DIM_CODE_MAX = (1 << CFG_W) - 1;
    localparam int DIM_CAP      = (MAX_DIM < DIM_CODE_MAX) ? MAX_DIM : DIM_CODE_MAX;
    localparam int STEP_W       = $clog2(POS_W);
    localparam logic [ADDR_W:0] DEPTH_V = (ADDR_W+1)'(STORE_DEPTH);

    typedef enum logic [4:0] {
        ST_LOAD = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_MOD  = 5'b01000,
        ST_RUN  = 5'b10000
    } setup_state_t;

    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0) return CFG_W'(1);
        if (32'(v) > 32'(DIM_CAP)) return CFG_W'(DIM_CAP);
        return v;
    endfunction

    function automatic logic [CFG_W:0] div_step(input logic [CFG_W-1:0] rem,
                                                input logic b,
                                                input logic [CFG_W-1:0] den);
        logic [CFG_W:0] t;
        logic [CFG_W:0] d;
        t = {rem, b};
        d = t - {1'b0, den};
        if (t >= {1'b0, den}) return {1'b1, d[CFG_W-1:0]};
        return {1'b0, t[CFG_W-1:0]};
    endfunction

    function automatic logic [ADDR_W-1:0] mod_step(input logic [ADDR_W-1:0] r,
                                                   input logic b);
        logic [ADDR_W:0] t;
        t = {r, b};
        if (t >= DEPTH_V) t = t - DEPTH_V;
        return t[ADDR_W-1:0];
    endfunction

    logic [CFG_W-1:0]  in_w_reg, in_h_reg, out_w_reg, out_h_reg;
    setup_state_t      state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CFG_W-1:0]  numx_reg, numy_reg, remx_reg, remy_reg, qx_reg, qy_reg;
    logic [POS_W-1:0]  frame_reg, sha_reg, shb_reg, shc_reg;
    logic [ADDR_W-1:0] ra_reg, rb_reg, rc_reg;
    logic [CFG_W-1:0]  iwe, ihe, owe, ohe;
    logic [CFG_W:0]    dx, dy;
    logic              cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart   = cfg_write;

    assign iwe = eff_dim(in_w_reg);
    assign ihe = eff_dim(in_h_reg);
    assign owe = eff_dim(out_w_reg);
    assign ohe = eff_dim(out_h_reg);

    assign dx = div_step(remx_reg, numx_reg[CFG_W-1], owe);
    assign dy = div_step(remy_reg, numy_reg[CFG_W-1], ohe);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        priority if (cfg_write) begin
            state_next = ST_LOAD;
            step_next  = '0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
                ST_DIV: begin
                    if (step_reg == STEP_W'(CFG_W - 1)) begin
                        state_next = ST_MUL;
                        step_next  = '0;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
                ST_MUL: begin
                    state_next = ST_MOD;
                    step_next  = '0;
                end
                ST_MOD: begin
                    if (step_reg == STEP_W'(POS_W - 1)) begin
                        state_next = ST_RUN;
                        step_next  = '0;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
                ST_RUN: begin
                    state_next = ST_RUN;
                end
                default: begin
                    state_next = ST_LOAD;
                    step_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_w_reg  <= DIM_RESET;
            in_h_reg  <= DIM_RESET;
            out_w_reg <= DIM_RESET;
            out_h_reg <= DIM_RESET;
            state_reg <= ST_LOAD;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg_write) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_IN_WIDTH:   in_w_reg  <= cfg_data;
                    REG_IN_HEIGHT:  in_h_reg  <= cfg_data;
                    REG_OUT_WIDTH:  out_w_reg <= cfg_data;
                    REG_OUT_HEIGHT: out_h_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_LOAD: begin
                numx_reg <= iwe;
                numy_reg <= ihe;
                remx_reg <= '0;
                remy_reg <= '0;
                qx_reg   <= '0;
                qy_reg   <= '0;
            end
            ST_DIV: begin
                remx_reg <= dx[CFG_W-1:0];
                remy_reg <= dy[CFG_W-1:0];
                qx_reg   <= {qx_reg[CFG_W-2:0], dx[CFG_W]};
                qy_reg   <= {qy_reg[CFG_W-2:0], dy[CFG_W]};
                numx_reg <= numx_reg << 1;
                numy_reg <= numy_reg << 1;
            end
            ST_MUL: begin
                sha_reg   <= POS_W'(qy_reg * iwe);
                frame_reg <= POS_W'(iwe * ihe);
                shb_reg   <= POS_W'(iwe);
                shc_reg   <= POS_W'(qx_reg);
                ra_reg    <= '0;
                rb_reg    <= '0;
                rc_reg    <= '0;
            end
            ST_MOD: begin
                ra_reg  <= mod_step(ra_reg, sha_reg[POS_W-1]);
                rb_reg  <= mod_step(rb_reg, shb_reg[POS_W-1]);
                rc_reg  <= mod_step(rc_reg, shc_reg[POS_W-1]);
                sha_reg <= sha_reg << 1;
                shb_reg <= shb_reg << 1;
                shc_reg <= shc_reg << 1;
            end
            ST_RUN: begin
                ra_reg <= ra_reg;
            end
            default: begin
                ra_reg <= ra_reg;
            end
        endcase
    end

    always_comb begin
        geom.done  = (state_reg == ST_RUN);
        geom.ow    = owe;
        geom.oh    = ohe;
        geom.rmx   = remx_reg;
        geom.rmy   = remy_reg;
        geom.frame = frame_reg;
    end

    assign qx_mod   = rc_reg;
    assign qyiw_mod = ra_reg;
    assign iw_mod   = rb_reg;

endmodule

[src/nnr_front.sv]
// Front end: accepts items, tracks load and target positions, forms store addresses.
// Depends on nnr_pkg; feeds nnr_queue.
module nnr_front import nnr_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    localparam int ADDR_W     = $clog2(STORE_DEPTH),
    localparam int ENTRY_W    = ADDR_W + RGB_W + 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               restart,
    input  geom_t              geom,
    input  logic [ADDR_W-1:0]  qx_mod,
    input  logic [ADDR_W-1:0]  qyiw_mod,
    input  logic [ADDR_W-1:0]  iw_mod,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [COLOR_W-1:0] s_red_in,
    input  logic [COLOR_W-1:0] s_green_in,
    input  logic [COLOR_W-1:0] s_blue_in,
    input  logic               q_full,
    output logic               q_push,
    output logic [ENTRY_W-1:0] q_data
);

    localparam logic [ADDR_W:0] DEPTH_V = (ADDR_W+1)'(STORE_DEPTH);

    function automatic logic [ADDR_W-1:0] add_mod(input logic [ADDR_W-1:0] a,
                                                  input logic [ADDR_W-1:0] b,
                                                  input logic c);
        logic [ADDR_W:0] t;
        t = {1'b0, a} + {1'b0, b} + {{ADDR_W{1'b0}}, c};
        if (t >= DEPTH_V) t = t - DEPTH_V;
        return t[ADDR_W-1:0];
    endfunction

    logic [CFG_W-1:0]  col_reg, row_reg, rx_reg, ry_reg;
    logic [ADDR_W-1:0] col_addr_reg, row_addr_reg, ld_addr_reg;
    logic [POS_W-1:0]  pos_reg;

    logic              accept, is_fetch, x_end, y_end, cx, cy, last, ld_wrap;
    logic [CFG_W:0]    rx_sum, ry_sum, rx_wrap, ry_wrap;
    logic [ADDR_W-1:0] col_step, row_mid, row_step, ld_addr_inc, addr;
    logic [POS_W:0]    pos_inc;

    assign s_ready  = geom.done && !q_full;
    assign accept   = s_valid && s_ready;
    assign is_fetch = (kind_t'(s_kind) == KIND_FETCH);

    assign x_end = (col_reg == geom.ow - 1'b1);
    assign y_end = (row_reg == geom.oh - 1'b1);
    assign last  = x_end && y_end;

    assign rx_sum  = {1'b0, rx_reg} + {1'b0, geom.rmx};
    assign cx      = (rx_sum >= {1'b0, geom.ow});
    assign rx_wrap = cx ? rx_sum - {1'b0, geom.ow} : rx_sum;
    assign ry_sum  = {1'b0, ry_reg} + {1'b0, geom.rmy};
    assign cy      = (ry_sum >= {1'b0, geom.oh});
    assign ry_wrap = cy ? ry_sum - {1'b0, geom.oh} : ry_sum;

    assign col_step = add_mod(col_addr_reg, qx_mod, cx);
    assign row_mid  = add_mod(row_addr_reg, qyiw_mod, 1'b0);
    assign row_step = add_mod(row_mid, cy ? iw_mod : '0, 1'b0);

    assign pos_inc     = {1'b0, pos_reg} + 1'b1;
    assign ld_wrap     = (pos_inc >= {1'b0, geom.frame});
    assign ld_addr_inc = (ld_addr_reg == ADDR_W'(STORE_DEPTH - 1)) ? '0
                                                                  : ld_addr_reg + 1'b1;

    assign addr   = is_fetch ? col_addr_reg : ld_addr_reg;
    assign q_push = accept;
    assign q_data = {s_kind, is_fetch && last, addr, s_red_in, s_green_in, s_blue_in};

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg      <= '0;
            row_reg      <= '0;
            rx_reg       <= '0;
            ry_reg       <= '0;
            col_addr_reg <= '0;
            row_addr_reg <= '0;
            pos_reg      <= '0;
            ld_addr_reg  <= '0;
        end else if (accept && is_fetch) begin
            if (!x_end) begin
                col_reg      <= col_reg + 1'b1;
                rx_reg       <= rx_wrap[CFG_W-1:0];
                col_addr_reg <= col_step;
            end else if (!y_end) begin
                col_reg      <= '0;
                rx_reg       <= '0;
                row_reg      <= row_reg + 1'b1;
                ry_reg       <= ry_wrap[CFG_W-1:0];
                row_addr_reg <= row_step;
                col_addr_reg <= row_step;
            end else begin
                col_reg      <= '0;
                rx_reg       <= '0;
                row_reg      <= '0;
                ry_reg       <= '0;
                row_addr_reg <= '0;
                col_addr_reg <= '0;
            end
        end else if (accept) begin
            if (ld_wrap) begin
                pos_reg     <= '0;
                ld_addr_reg <= '0;
            end else begin
                pos_reg     <= pos_inc[POS_W-1:0];
                ld_addr_reg <= ld_addr_inc;
            end
        end
    end

endmodule

[src/nnr_queue.sv]
// Short FIFO between the front end and the frame store side.
// Depends on nnr_pkg for its depth.
module nnr_queue import nnr_pkg::*; #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] data_in,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] data_out,
    output logic         empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign data_out = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= data_in;
    end

endmodule

[src/nnr_back.sv]
// Back end: frame store writes and reads, registered read stage and result register.
// Depends on nnr_pkg; drains nnr_queue.
module nnr_back import nnr_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    localparam int ADDR_W     = $clog2(STORE_DEPTH),
    localparam int ENTRY_W    = ADDR_W + RGB_W + 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic [ENTRY_W-1:0] q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COLOR_W-1:0] m_red_out,
    output logic [COLOR_W-1:0] m_green_out,
    output logic [COLOR_W-1:0] m_blue_out,
    output logic               m_last
);

    logic [RGB_W-1:0] store [STORE_DEPTH];

    logic              rd_valid_reg, rd_last_reg, m_valid_reg, m_last_reg;
    logic [RGB_W-1:0]  rd_data_reg, m_data_reg;
    logic              head_fetch, out_free, rd_move, rd_free, fetch_pop, load_pop;
    logic [ADDR_W-1:0] head_addr;

    assign head_fetch = (kind_t'(q_data[ENTRY_W-1]) == KIND_FETCH);
    assign head_addr  = q_data[RGB_W +: ADDR_W];

    assign out_free  = !m_valid_reg || m_ready;
    assign rd_move   = rd_valid_reg && out_free;
    assign rd_free   = !rd_valid_reg || rd_move;
    assign q_pop     = !q_empty && (!head_fetch || rd_free);
    assign fetch_pop = q_pop && head_fetch;
    assign load_pop  = q_pop && !head_fetch;

    always_ff @(posedge aclk) begin
        if (load_pop)  store[head_addr] <= q_data[RGB_W-1:0];
        if (fetch_pop) rd_data_reg <= store[head_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg <= (rd_valid_reg && !rd_move) || fetch_pop;
            m_valid_reg  <= rd_move || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (fetch_pop) rd_last_reg <= q_data[ENTRY_W-2];
        if (rd_move) begin
            m_data_reg <= rd_data_reg;
            m_last_reg <= rd_last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = m_data_reg[2*COLOR_W +: COLOR_W];
    assign m_green_out = m_data_reg[COLOR_W +: COLOR_W];
    assign m_blue_out  = m_data_reg[0 +: COLOR_W];
    assign m_last      = m_last_reg;

endmodule

[src/nearest_neighbor_resizer_unit.sv]
// Top level of the nearest-neighbor resizer: setup, front end, queue, back end.
// Depends on nnr_pkg, nnr_setup, nnr_front, nnr_queue and nnr_back.
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    s_kind, s_red_in, s_green_in, s_blue_in
//   m_       out        m_valid / m_ready    m_red_out, m_green_out, m_blue_out, m_last
//   cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One load or fetch per clock while s_ready is high; fetches go through the read register.
// After reset and after every register write the setup sequencer runs its steps
// (1 load, 9 divide steps, 1 multiply, 18 reduction steps) with s_ready low.
// The 4-entry queue lets the front keep taking items while m_ready is low until it fills.
// cfg_ready is always high; any register write restarts the load and target positions.
module nearest_neighbor_resizer_unit import nnr_pkg::*; #(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [COLOR_W-1:0]   s_red_in,
    input  logic [COLOR_W-1:0]   s_green_in,
    input  logic [COLOR_W-1:0]   s_blue_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [COLOR_W-1:0]   m_red_out,
    output logic [COLOR_W-1:0]   m_green_out,
    output logic [COLOR_W-1:0]   m_blue_out,
    output logic                 m_last
);

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int ENTRY_W = ADDR_W + RGB_W + 2;

    geom_t              geom;
    logic               restart;
    logic [ADDR_W-1:0]  qx_mod, qyiw_mod, iw_mod;
    logic               q_push, q_pop, q_full, q_empty;
    logic [ENTRY_W-1:0] q_in, q_out;

    nnr_setup #(
        .MAX_DIM     (MAX_DIM),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .restart   (restart),
        .geom      (geom),
        .qx_mod    (qx_mod),
        .qyiw_mod  (qyiw_mod),
        .iw_mod    (iw_mod)
    );

    nnr_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (restart),
        .geom       (geom),
        .qx_mod     (qx_mod),
        .qyiw_mod   (qyiw_mod),
        .iw_mod     (iw_mod),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_red_in   (s_red_in),
        .s_green_in (s_green_in),
        .s_blue_in  (s_blue_in),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    nnr_queue #(
        .W (ENTRY_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .data_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .data_out (q_out),
        .empty    (q_empty)
    );

    nnr_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_data      (q_out),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_last      (m_last)
    );

`ifndef SYNTHESIS
    a_cfg_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> !s_ready)
        else $error("input taken during setup after a register write");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_pop && q_empty))
        else $error("queue read while empty");
`endif

endmodule

[dv/testbench.sv]
// Self-checking testbench for nearest_neighbor_resizer_unit: a directed table of loads and
// fetches with expected pixels, then corner and random frames checked by a local mapping.
// Depends on nnr_pkg and the resizer RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import nnr_pkg::*;

    localparam int IDLE_PCT      = 31;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int CORNER_MIX    = 40;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               last;
    } pixel_t;

    typedef struct packed {
        kind_t              kind;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               typed;
        pixel_t             want;
    } stim_row_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    cfg_reg_t           cfg_index   = REG_IN_WIDTH;
    logic [CFG_W-1:0]   cfg_data    = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    kind_t              s_kind      = KIND_LOAD;
    logic [COLOR_W-1:0] s_red_in    = '0;
    logic [COLOR_W-1:0] s_green_in  = '0;
    logic [COLOR_W-1:0] s_blue_in   = '0;
    logic               stim_typed  = 1'b0;
    pixel_t             stim_want   = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [COLOR_W-1:0] m_red_out;
    logic [COLOR_W-1:0] m_green_out;
    logic [COLOR_W-1:0] m_blue_out;
    logic               m_last;

    logic [CFG_W-1:0]     in_w_reg  = DIM_RESET;
    logic [CFG_W-1:0]     in_h_reg  = DIM_RESET;
    logic [CFG_W-1:0]     out_w_reg = DIM_RESET;
    logic [CFG_W-1:0]     out_h_reg = DIM_RESET;
    logic [RGB_W-1:0]     src_frame [STORE_DEPTH_DEF];
    int unsigned          load_pos  = 0;
    int unsigned          target_x  = 0;
    int unsigned          target_y  = 0;
    pixel_t               expected_pixels [$];
    int unsigned          mismatches   = 0;
    int unsigned          items_sent   = 0;
    int unsigned          quiet_cycles = 0;
    bit                   steady       = 1'b0;

    stim_row_t directed_rows [14] = '{
        '{KIND_LOAD,  8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{KIND_LOAD,  8'hFF, 8'hFF, 8'hFF, 1'b0, '0},
        '{KIND_LOAD,  8'h55, 8'hAA, 8'h0F, 1'b0, '0},
        '{KIND_LOAD,  8'hAA, 8'h55, 8'hF0, 1'b0, '0},
        '{KIND_FETCH, 8'hFF, 8'h00, 8'hFF, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{KIND_FETCH, 8'h00, 8'hFF, 8'h00, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
        '{KIND_FETCH, 8'h81, 8'h7E, 8'h18, 1'b1, '{8'h55, 8'hAA, 8'h0F, 1'b0}},
        '{KIND_FETCH, 8'h7E, 8'h81, 8'hE7, 1'b1, '{8'hAA, 8'h55, 8'hF0, 1'b1}},
        '{KIND_LOAD,  8'h12, 8'h34, 8'h56, 1'b0, '0},
        '{KIND_FETCH, 8'h00, 8'h00, 8'h00, 1'b1, '{8'h12, 8'h34, 8'h56, 1'b0}},
        '{KIND_LOAD,  8'hC3, 8'h3C, 8'h99, 1'b0, '0},
        '{KIND_FETCH, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{8'hC3, 8'h3C, 8'h99, 1'b0}},
        '{KIND_FETCH, 8'h5A, 8'h5A, 8'h5A, 1'b0, '0},
        '{KIND_FETCH, 8'hA5, 8'hA5, 8'hA5, 1'b0, '0}
    };

    logic [CFG_W-1:0] corner_geoms [5][4] = '{
        '{9'd511, 9'd1,   9'd256, 9'd2},
        '{9'd0,   9'd257, 9'd0,   9'd511},
        '{9'd1,   9'd1,   9'd1,   9'd1},
        '{9'd3,   9'd5,   9'd256, 9'd1},
        '{9'd5,   9'd3,   9'd1,   9'd256}
    };

    nearest_neighbor_resizer_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_last      (m_last)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
        return v;
    endfunction

    function automatic void store_source_pixel(logic [RGB_W-1:0] rgb);
        int unsigned frame_pixels;
        frame_pixels = clamp_dim(in_w_reg) * clamp_dim(in_h_reg);
        if (load_pos >= frame_pixels) load_pos = 0;
        src_frame[load_pos % STORE_DEPTH_DEF] = rgb;
        load_pos = (load_pos + 1 >= frame_pixels) ? 0 : load_pos + 1;
    endfunction

    function automatic pixel_t next_target_pixel();
        int unsigned iw, ih, ow, oh, sx, sy;
        pixel_t px;
        iw = clamp_dim(in_w_reg);
        ih = clamp_dim(in_h_reg);
        ow = clamp_dim(out_w_reg);
        oh = clamp_dim(out_h_reg);
        if (target_x >= ow) target_x = 0;
        if (target_y >= oh) target_y = 0;
        sx = target_x * iw / ow;
        sy = target_y * ih / oh;
        {px.red, px.green, px.blue} = src_frame[(sy * iw + sx) % STORE_DEPTH_DEF];
        px.last = (target_x == ow - 1) && (target_y == oh - 1);
        target_x++;
        if (target_x >= ow) begin
            target_x = 0;
            target_y = (target_y + 1 >= oh) ? 0 : target_y + 1;
        end
        return px;
    endfunction

    function automatic stim_row_t random_item(kind_t kind);
        stim_row_t row;
        row = '0;
        row.kind  = kind;
        row.red   = COLOR_W'($urandom);
        row.green = COLOR_W'($urandom);
        row.blue  = COLOR_W'($urandom);
        return row;
    endfunction

    function automatic logic [CFG_W-1:0] random_dim(int unsigned hi, bit wide);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1 && wide) return CFG_W'($urandom_range(1, (1 << CFG_W) - 1));
        if (pick == 1) return CFG_W'($urandom_range(1, 5 * hi));
        return CFG_W'($urandom_range(1, hi));
    endfunction

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic apply_geometry(logic [CFG_W-1:0] iw, logic [CFG_W-1:0] ih,
                                  logic [CFG_W-1:0] ow, logic [CFG_W-1:0] oh);
        drain_results();
        cfg_write(REG_IN_WIDTH, iw);
        cfg_write(REG_IN_HEIGHT, ih);
        cfg_write(REG_OUT_WIDTH, ow);
        cfg_write(REG_OUT_HEIGHT, oh);
        cfg_valid <= 1'b0;
    endtask

    task automatic transfer_item(stim_row_t row);
        steady = items_sent >= 1200 && items_sent < 1500;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_kind     <= row.kind;
        s_red_in   <= row.red;
        s_green_in <= row.green;
        s_blue_in  <= row.blue;
        stim_typed <= row.typed;
        stim_want  <= row.want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic run_frame(logic [CFG_W-1:0] iw, logic [CFG_W-1:0] ih,
                             logic [CFG_W-1:0] ow, logic [CFG_W-1:0] oh, int unsigned mix);
        apply_geometry(iw, ih, ow, oh);
        repeat (clamp_dim(iw) * clamp_dim(ih)) transfer_item(random_item(KIND_LOAD));
        repeat (mix) begin
            if ($urandom_range(0, 99) == 0) drain_results();
            transfer_item(random_item($urandom_range(0, 4) == 0 ? KIND_LOAD : KIND_FETCH));
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_IN_WIDTH:   in_w_reg  = cfg_data;
                REG_IN_HEIGHT:  in_h_reg  = cfg_data;
                REG_OUT_WIDTH:  out_w_reg = cfg_data;
                REG_OUT_HEIGHT: out_h_reg = cfg_data;
                default: ;
            endcase
            load_pos = 0;
            target_x = 0;
            target_y = 0;
        end
        if (aresetn && s_valid && s_ready) begin
            if (s_kind == KIND_LOAD) begin
                store_source_pixel({s_red_in, s_green_in, s_blue_in});
            end else begin
                want = next_target_pixel();
                expected_pixels.push_back(stim_typed ? stim_want : want);
            end
        end
        if (aresetn && m_valid && m_ready) begin
            got = '{m_red_out, m_green_out, m_blue_out, m_last};
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: pixel with nothing expected: r=%h g=%h b=%h last=%b",
                             $realtime, got.red, got.green, got.blue, got.last);
            end else begin
                want = expected_pixels.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: expected r=%h g=%h b=%h last=%b, got r=%h g=%h b=%h last=%b",
                                 $realtime, want.red, want.green, want.blue, want.last,
                                 got.red, got.green, got.blue, got.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned random_start;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        apply_geometry(9'd2, 9'd2, 9'd2, 9'd2);
        foreach (directed_rows[i]) transfer_item(directed_rows[i]);
        foreach (corner_geoms[p])
            run_frame(corner_geoms[p][0], corner_geoms[p][1], corner_geoms[p][2],
                      corner_geoms[p][3], CORNER_MIX);
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
            run_frame(random_dim(8, 1'b0), random_dim(8, 1'b0), random_dim(10, 1'b1),
                      random_dim(10, 1'b1), $urandom_range(60, 160));
        drain_results();
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
